/* rtl/aabb_pkg.sv */
// ----------------------------------------------------------------------------
// aabb_pkg
// Shared types, constants and box test helpers for the aabb pair collision
// query block.
// ----------------------------------------------------------------------------
package aabb_pkg;

  // table size and derived widths
  localparam int unsigned MaxEntities = 32;
  localparam int unsigned SlotW       = 5;
  localparam int unsigned IdxW        = (MaxEntities > 1) ? $clog2(MaxEntities) : 1;
  localparam int unsigned CntW        = IdxW + 1;
  localparam int unsigned WideW       = IdxW + SlotW;
  localparam int unsigned QueueDepth  = 2;
  localparam int unsigned CoordW      = 16;
  localparam int unsigned SigW        = 8;

  typedef logic [IdxW-1:0] idx_t;

  typedef enum logic {
    FuncWrite = 1'b0,
    FuncQuery = 1'b1
  } func_e;

  // one slot of the entity table
  typedef struct packed {
    logic                     is_player;
    logic [SigW-1:0]          signature;
    logic                     active;
    logic signed [CoordW-1:0] pos_x;
    logic signed [CoordW-1:0] pos_y;
    logic signed [CoordW-1:0] pos_z;
    logic [CoordW-1:0]        ext_x;
    logic [CoordW-1:0]        ext_y;
    logic [CoordW-1:0]        ext_z;
  } entry_t;

  // classified word passed from front to back
  typedef struct packed {
    logic             is_query;
    logic             in_range;
    logic [SlotW-1:0] slot;
    idx_t             idx;
    entry_t           entry;
  } cmd_t;

  function automatic idx_t slot_to_idx(logic [SlotW-1:0] s);
    logic [WideW-1:0] w;
    w = WideW'(s);
    return w[IdxW-1:0];
  endfunction

  function automatic logic [SlotW-1:0] idx_to_slot(idx_t i);
    logic [WideW-1:0] w;
    w = WideW'(i);
    return w[SlotW-1:0];
  endfunction

  function automatic logic slot_in_range(logic [SlotW-1:0] s);
    return WideW'(s) < WideW'(MaxEntities);
  endfunction

  function automatic logic eligible(entry_t e, logic [SigW-1:0] mask);
    return e.active && ((e.signature & mask) == mask);
  endfunction

  // inclusive interval test on one axis, bounds are 2*pos +/- extent
  function automatic logic axis_hit(logic signed [CoordW-1:0] p1, logic [CoordW-1:0] e1,
                                    logic signed [CoordW-1:0] p2, logic [CoordW-1:0] e2);
    logic signed [CoordW+1:0] lo1;
    logic signed [CoordW+1:0] hi1;
    logic signed [CoordW+1:0] lo2;
    logic signed [CoordW+1:0] hi2;
    lo1 = $signed({p1[CoordW-1], p1, 1'b0}) - $signed({2'b00, e1});
    hi1 = $signed({p1[CoordW-1], p1, 1'b0}) + $signed({2'b00, e1});
    lo2 = $signed({p2[CoordW-1], p2, 1'b0}) - $signed({2'b00, e2});
    hi2 = $signed({p2[CoordW-1], p2, 1'b0}) + $signed({2'b00, e2});
    return (lo1 <= hi2) && (hi1 >= lo2);
  endfunction

  function automatic logic box_overlap(entry_t a, entry_t b);
    return axis_hit(a.pos_x, a.ext_x, b.pos_x, b.ext_x) &&
           axis_hit(a.pos_y, a.ext_y, b.pos_y, b.ext_y) &&
           axis_hit(a.pos_z, a.ext_z, b.pos_z, b.ext_z);
  endfunction

endpackage

/* rtl/aabb_ram.sv */
// ----------------------------------------------------------------------------
// aabb_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module aabb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, holds when not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/aabb_front.sv */
// ----------------------------------------------------------------------------
// aabb_front
// Accepts input words, classifies them as slot writes or queries with a
// range check, and holds them in a short queue for the back end.
// ----------------------------------------------------------------------------
module aabb_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         func_i,
  input  logic [aabb_pkg::SlotW-1:0]   slot_i,
  input  aabb_pkg::entry_t             entry_i,
  output logic                         cmd_valid_o,
  output aabb_pkg::cmd_t               cmd_o,
  input  logic                         cmd_pop_i
);

  localparam int unsigned PtrW = (aabb_pkg::QueueDepth > 1) ?
                                 $clog2(aabb_pkg::QueueDepth) : 1;

  aabb_pkg::cmd_t queue_q [aabb_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]   count_q, count_d;
  aabb_pkg::cmd_t  cmd_in;
  logic            push, pop;

  // classify the incoming word
  always_comb begin
    cmd_in          = '0;
    cmd_in.is_query = (aabb_pkg::func_e'(func_i) == aabb_pkg::FuncQuery);
    cmd_in.in_range = aabb_pkg::slot_in_range(slot_i);
    cmd_in.slot     = slot_i;
    cmd_in.idx      = aabb_pkg::slot_to_idx(slot_i);
    cmd_in.entry    = entry_i;
  end

  assign in_ready_o  = (count_q != (PtrW+1)'(aabb_pkg::QueueDepth));
  assign push        = in_valid_i && in_ready_o;
  assign cmd_valid_o = (count_q != '0);
  assign pop         = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = queue_q[rd_ptr_q];

  // pointer and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(aabb_pkg::QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(aabb_pkg::QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

/* rtl/aabb_back.sv */
// ----------------------------------------------------------------------------
// aabb_back
// Executes queued words: stores slot writes in table RAM; a query walks the
// table one slot per cycle barring stalls, one word per hit or one empty word.
// ----------------------------------------------------------------------------
module aabb_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [aabb_pkg::SigW-1:0]         mask_i,
  input  logic                              cmd_valid_i,
  input  aabb_pkg::cmd_t                    cmd_i,
  output logic                              cmd_pop_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [aabb_pkg::SlotW-1:0]        first_index_o,
  output logic [aabb_pkg::SlotW-1:0]        second_index_o,
  output logic                              hit_o,
  output logic                              last_o
);

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StSelf = 4'b0010,
    StScan = 4'b0100,
    StFin  = 4'b1000
  } state_e;

  state_e                          state_q, state_d;
  logic [aabb_pkg::MaxEntities-1:0] valid_q;
  aabb_pkg::entry_t                self_q, self_d;
  aabb_pkg::idx_t                  self_idx_q, self_idx_d;
  logic [aabb_pkg::SlotW-1:0]      slot_q, slot_d;
  logic [aabb_pkg::CntW-1:0]       scan_q, scan_d;
  logic                            chk_v_q, chk_v_d;
  aabb_pkg::idx_t                  chk_idx_q, chk_idx_d;
  logic                            pend_v_q, pend_v_d;
  aabb_pkg::idx_t                  pend_idx_q, pend_idx_d;
  logic                            out_v_q;
  logic [aabb_pkg::SlotW-1:0]      out_first_q, out_second_q;
  logic                            out_hit_q, out_last_q;

  logic                            push;
  logic [aabb_pkg::SlotW-1:0]      push_second;
  logic                            push_hit, push_last;
  logic                            can_push, cand, stall, scan_done;
  logic                            ram_we, ram_re;
  aabb_pkg::idx_t                  ram_raddr;
  logic [$bits(aabb_pkg::entry_t)-1:0] ram_rdata;
  aabb_pkg::entry_t                rd_entry;

  // table memory, one entry per slot
  aabb_ram #(
    .Width($bits(aabb_pkg::entry_t)),
    .Depth(aabb_pkg::MaxEntities)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(cmd_i.idx),
    .wdata_i(cmd_i.entry),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign rd_entry  = aabb_pkg::entry_t'(ram_rdata);
  assign can_push  = !out_v_q || out_ready_i;
  assign scan_done = (scan_q == aabb_pkg::CntW'(aabb_pkg::MaxEntities));

  // partner test on the slot held in the registered read data
  assign cand = chk_v_q && valid_q[chk_idx_q] && aabb_pkg::eligible(rd_entry, mask_i) &&
                (chk_idx_q != self_idx_q) && aabb_pkg::box_overlap(self_q, rd_entry) &&
                (self_q.is_player || rd_entry.is_player);
  assign stall = cand && pend_v_q && !can_push;

  // sequencer
  always_comb begin
    state_d     = state_q;
    self_d      = self_q;
    self_idx_d  = self_idx_q;
    slot_d      = slot_q;
    scan_d      = scan_q;
    chk_v_d     = chk_v_q;
    chk_idx_d   = chk_idx_q;
    pend_v_d    = pend_v_q;
    pend_idx_d  = pend_idx_q;
    push        = 1'b0;
    push_second = '0;
    push_hit    = 1'b0;
    push_last   = 1'b0;
    cmd_pop_o   = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_raddr   = cmd_i.idx;
    case (state_q)
      StIdle: begin
        if (cmd_valid_i) begin
          slot_d     = cmd_i.slot;
          self_idx_d = cmd_i.idx;
          pend_v_d   = 1'b0;
          if (!cmd_i.is_query) begin
            cmd_pop_o = 1'b1;
            ram_we    = cmd_i.in_range;
          end else if (cmd_i.in_range) begin
            ram_re  = 1'b1;
            state_d = StSelf;
          end else begin
            state_d = StFin;
          end
        end
      end
      StSelf: begin
        self_d  = rd_entry;
        chk_v_d = 1'b0;
        scan_d  = '0;
        if (valid_q[self_idx_q] && aabb_pkg::eligible(rd_entry, mask_i)) begin
          state_d = StScan;
        end else begin
          state_d = StFin;
        end
      end
      StScan: begin
        if (!stall) begin
          // hold the newest hit back so the final one can carry last
          if (cand) begin
            if (pend_v_q) begin
              push        = 1'b1;
              push_second = aabb_pkg::idx_to_slot(pend_idx_q);
              push_hit    = 1'b1;
            end
            pend_v_d   = 1'b1;
            pend_idx_d = chk_idx_q;
          end
          if (!scan_done) begin
            ram_re    = 1'b1;
            ram_raddr = scan_q[aabb_pkg::IdxW-1:0];
            chk_v_d   = 1'b1;
            chk_idx_d = scan_q[aabb_pkg::IdxW-1:0];
            scan_d    = scan_q + 1'b1;
          end else begin
            chk_v_d = 1'b0;
            if (!chk_v_q) begin
              state_d = StFin;
            end
          end
        end
      end
      StFin: begin
        if (can_push) begin
          push        = 1'b1;
          push_second = pend_v_q ? aabb_pkg::idx_to_slot(pend_idx_q) : '0;
          push_hit    = pend_v_q;
          push_last   = 1'b1;
          cmd_pop_o   = 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      valid_q  <= '0;
      chk_v_q  <= 1'b0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      chk_v_q  <= chk_v_d;
      pend_v_q <= pend_v_d;
      if (ram_we) begin
        valid_q[cmd_i.idx] <= 1'b1;
      end
      if (push) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    self_q     <= self_d;
    self_idx_q <= self_idx_d;
    slot_q     <= slot_d;
    scan_q     <= scan_d;
    chk_idx_q  <= chk_idx_d;
    pend_idx_q <= pend_idx_d;
    if (push) begin
      out_first_q  <= slot_q;
      out_second_q <= push_second;
      out_hit_q    <= push_hit;
      out_last_q   <= push_last;
    end
  end

  assign out_valid_o    = out_v_q;
  assign first_index_o  = out_first_q;
  assign second_index_o = out_second_q;
  assign hit_o          = out_hit_q;
  assign last_o         = out_last_q;

endmodule

/* rtl/aabb_pair_collision_query.sv */
// ----------------------------------------------------------------------------
// aabb_pair_collision_query
// Entity table with axis-aligned box overlap queries against all other slots.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one word per item. func_i
//   low writes slot_i with flags, centre and extent; func_i high queries
//   slot_i against every other eligible slot in ascending order.
//   Output channel (out_valid_o/out_ready_i) returns one word per reported
//   hit, or a single empty word (hit_o low) when nothing is reported; last_o
//   marks the final word of each query.
//   A two-entry queue sits between input and the executing back end, so new
//   words are taken while a query is still running or its results wait.
//   Timing: a write passes through the queue and is then written into the
//   table RAM. A query runs through queue hand-off, self read, a read of
//   every slot one per cycle, test of the last slot, finish and final word;
//   queries run one at a time, and finishing waits while the receiver
//   stalls. The walk pauses only when a hit must be handed over and the
//   output register is still full.
//   Reset clears all slot valid bits (every slot inactive) and required_mask;
//   no clearing pass runs. cfg_we_i writes required_mask; the user must do so
//   only while idle, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
module aabb_pair_collision_query (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [7:0]          cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                func_i,
  input  logic [4:0]          slot_i,
  input  logic                active_i,
  input  logic [7:0]          signature_i,
  input  logic                is_player_i,
  input  logic signed [15:0]  pos_x_i,
  input  logic signed [15:0]  pos_y_i,
  input  logic signed [15:0]  pos_z_i,
  input  logic [15:0]         ext_x_i,
  input  logic [15:0]         ext_y_i,
  input  logic [15:0]         ext_z_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [4:0]          first_index_o,
  output logic [4:0]          second_index_o,
  output logic                hit_o,
  output logic                last_o
);

  logic [aabb_pkg::SigW-1:0] mask_q;
  aabb_pkg::entry_t          entry_in;
  logic                      cmd_valid;
  aabb_pkg::cmd_t            cmd;
  logic                      cmd_pop;

  // required mask register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else if (cfg_we_i) begin
      mask_q <= cfg_wdata_i;
    end
  end

  // pack the slot payload
  always_comb begin
    entry_in.is_player = is_player_i;
    entry_in.signature = signature_i;
    entry_in.active    = active_i;
    entry_in.pos_x     = pos_x_i;
    entry_in.pos_y     = pos_y_i;
    entry_in.pos_z     = pos_z_i;
    entry_in.ext_x     = ext_x_i;
    entry_in.ext_y     = ext_y_i;
    entry_in.ext_z     = ext_z_i;
  end

  aabb_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .func_i     (func_i),
    .slot_i     (slot_i),
    .entry_i    (entry_in),
    .cmd_valid_o(cmd_valid),
    .cmd_o      (cmd),
    .cmd_pop_i  (cmd_pop)
  );

  aabb_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .mask_i        (mask_q),
    .cmd_valid_i   (cmd_valid),
    .cmd_i         (cmd),
    .cmd_pop_o     (cmd_pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .first_index_o (first_index_o),
    .second_index_o(second_index_o),
    .hit_o         (hit_o),
    .last_o        (last_o)
  );

`ifndef ASSERT_OFF
  // an empty answer is always the final word and names partner zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o |-> last_o && (second_index_o == '0))
    else $error("empty answer without last or with nonzero partner");

  // a slot never reports a hit against itself
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hit_o |-> first_index_o != second_index_o)
    else $error("hit reported against the queried slot itself");

  // a non-final hit means the query is still held at the queue head
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hit_o && !last_o |-> cmd_valid && cmd.is_query)
    else $error("non-final hit without a pending query");

  // the back end never pops an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> cmd_valid)
    else $error("queue popped while empty");
`endif

endmodule
